// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mbc_pkg.sv =====
`timescale 1ns / 1ps
package mbc_pkg;

  localparam int VW = 30;
  localparam int MUL_LAT = 5;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PW = 4;

  typedef logic [VW-1:0] val_t;

  typedef struct packed {
    val_t a_x;
    val_t a_y;
    val_t b_x;
    val_t b_y;
  } mul_req_t;

  typedef struct packed {
    logic we;
    val_t fac;
    val_t ifac;
  } tbl_wr_t;

endpackage

// ===== rtl/mbc_modmul.sv =====
`timescale 1ns / 1ps
module mbc_modmul import mbc_pkg::*; #(
  parameter int MODULUS = 1000000007
) (
  input  logic clk,
  input  val_t x,
  input  val_t y,
  output val_t z
);

  localparam int K = $clog2(MODULUS);
  localparam logic [63:0] MU64 = (64'd1 << (2 * K)) / 64'(MODULUS);
  localparam logic [K:0] MU = MU64[K:0];
  localparam logic [K-1:0] MK = K'(MODULUS);
  localparam logic [K+1:0] MK2 = (K+2)'(MODULUS);

  logic [2*VW-1:0] prod0;
  logic [2*VW-1:0] prod1;
  logic [2*K+1:0]  q2;
  logic [K:0]      q3;
  logic [2*K:0]    qm;
  logic [K+1:0]    r0;
  logic [K+1:0]    r1;

  assign q3 = q2[2*K+1:K+1];
  assign qm = q3 * MK;

  always_ff @(posedge clk) begin
    prod0 <= x * y;
    q2    <= prod0[2*K-1:K-1] * MU;
    prod1 <= prod0;
    r0    <= prod1[K+1:0] - qm[K+1:0];
    r1    <= (r0 >= MK2) ? r0 - MK2 : r0;
    z     <= VW'((r1 >= MK2) ? r1 - MK2 : r1);
  end

endmodule

// ===== rtl/mbc_tables.sv =====
`timescale 1ns / 1ps
module mbc_tables import mbc_pkg::*; #(
  parameter int TABLE_SIZE = 2048
) (
  input  logic                          clk,
  input  tbl_wr_t                       wr,
  input  logic [$clog2(TABLE_SIZE)-1:0] waddr,
  input  logic [$clog2(TABLE_SIZE)-1:0] fac_addr,
  input  logic [$clog2(TABLE_SIZE)-1:0] ifac_addr_a,
  input  logic [$clog2(TABLE_SIZE)-1:0] ifac_addr_b,
  output val_t                          fac_rd,
  output val_t                          ifac_rd_a,
  output val_t                          ifac_rd_b
);

  val_t fac_mem [TABLE_SIZE];
  val_t ifac_mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      fac_mem[waddr]  <= wr.fac;
      ifac_mem[waddr] <= wr.ifac;
    end
    fac_rd    <= fac_mem[fac_addr];
    ifac_rd_a <= ifac_mem[ifac_addr_a];
    ifac_rd_b <= ifac_mem[ifac_addr_b];
  end

endmodule

// ===== rtl/mbc_init.sv =====
`timescale 1ns / 1ps
module mbc_init import mbc_pkg::*; #(
  parameter int TABLE_SIZE = 2048,
  parameter int MODULUS = 1000000007
) (
  input  logic                          clk,
  input  logic                          rst,
  input  val_t                          a_out,
  input  val_t                          b_out,
  output mul_req_t                      req,
  output tbl_wr_t                       wr,
  output logic [$clog2(TABLE_SIZE)-1:0] waddr,
  output logic                          ready
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int K = $clog2(MODULUS);
  localparam int LW = $clog2(MUL_LAT);
  localparam logic [K-1:0] EXP0 = K'(MODULUS - 2);
  localparam logic [K-1:0] MLAST = K'(MODULUS - 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);
  localparam logic [LW-1:0] WAIT0 = LW'(MUL_LAT - 1);

  typedef enum logic [5:0] {
    ST_BOOT       = 6'b000001,
    ST_POW_ISSUE  = 6'b000010,
    ST_POW_WAIT   = 6'b000100,
    ST_STEP_ISSUE = 6'b001000,
    ST_STEP_WAIT  = 6'b010000,
    ST_READY      = 6'b100000
  } state_t;

  state_t        state;
  logic [IW-1:0] idx;
  logic [K-1:0]  iv;
  logic [K-1:0]  iv_next;
  logic [K-1:0]  exp_sh;
  logic [LW-1:0] cnt;
  val_t          base;
  val_t          acc;
  val_t          fac_prev;
  val_t          ifac_prev;

  assign iv_next = (iv == MLAST) ? '0 : iv + 1'b1;
  assign ready = (state == ST_READY);

  always_comb begin
    req.a_x = acc;
    req.a_y = base;
    req.b_x = base;
    req.b_y = base;
    wr.we   = 1'b0;
    wr.fac  = a_out;
    wr.ifac = b_out;
    waddr   = idx;
    unique case (state)
      ST_BOOT: begin
        wr.we   = 1'b1;
        wr.fac  = VW'(1);
        wr.ifac = VW'(1);
        waddr   = '0;
      end
      ST_STEP_ISSUE: begin
        req.a_x = fac_prev;
        req.a_y = VW'(iv);
        req.b_x = ifac_prev;
        req.b_y = acc;
      end
      ST_STEP_WAIT: wr.we = (cnt == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT;
    end else begin
      unique case (state)
        ST_BOOT: begin
          fac_prev  <= VW'(1);
          ifac_prev <= VW'(1);
          idx       <= IW'(1);
          iv        <= K'(1);
          base      <= VW'(1);
          acc       <= VW'(1);
          exp_sh    <= EXP0;
          state     <= ST_POW_ISSUE;
        end
        ST_POW_ISSUE: begin
          cnt <= WAIT0;
          if (exp_sh == '0) begin
            state <= ST_STEP_ISSUE;
          end else begin
            state <= ST_POW_WAIT;
          end
        end
        ST_POW_WAIT: begin
          if (cnt == '0) begin
            if (exp_sh[0]) begin
              acc <= a_out;
            end
            base   <= b_out;
            exp_sh <= exp_sh >> 1;
            state  <= ST_POW_ISSUE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_STEP_ISSUE: begin
          cnt   <= WAIT0;
          state <= ST_STEP_WAIT;
        end
        ST_STEP_WAIT: begin
          if (cnt == '0) begin
            fac_prev  <= a_out;
            ifac_prev <= b_out;
            if (idx == LAST) begin
              state <= ST_READY;
            end else begin
              idx    <= idx + 1'b1;
              iv     <= iv_next;
              base   <= VW'(iv_next);
              acc    <= VW'(1);
              exp_sh <= EXP0;
              state  <= ST_POW_ISSUE;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_READY: state <= ST_READY;
        default: state <= ST_BOOT;
      endcase
    end
  end

endmodule

// ===== rtl/modular_binomial_coefficient.sv =====
`timescale 1ns / 1ps
// Binomial coefficient C(top_count, pick_count) modulo MODULUS.
// Request channel: req_valid / req_stall carry top_count and pick_count,
// both 12-bit two's complement. Result channel: coefficient_valid /
// coefficient_stall carry the 30-bit coefficient, zero when either count is
// negative, pick exceeds top, or top is outside the table.
// After reset the block builds its factorial and inverse-factorial tables
// with a shared pair of modular multipliers; each inverse step raises the
// index to MODULUS-2 by square-and-multiply. req_stall stays high until the
// tables are built. Then one request is taken every cycle while req_stall is
// low. A result passes through one memory read and two chained 5-stage
// multipliers before it enters the result FIFO.
// Results queue in a 16-entry FIFO; a stalled receiver holds the head
// result steady, and req_stall rises once 16 requests are outstanding.
module modular_binomial_coefficient import mbc_pkg::*; #(
  parameter int TABLE_SIZE = 2048,
  parameter int MODULUS = 1000000007
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic signed [11:0] top_count,
  input  logic signed [11:0] pick_count,
  output logic              coefficient_valid,
  input  logic              coefficient_stall,
  output logic [29:0]       coefficient
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int AW = (IW > 12) ? IW : 12;
  localparam int L = MUL_LAT;
  localparam int D = 2 * L + 1;
  localparam logic [FIFO_PW:0] DEPTH = (FIFO_PW + 1)'(FIFO_DEPTH);

  mul_req_t      init_req;
  tbl_wr_t       wr;
  logic [IW-1:0] waddr;
  logic          tables_ready;
  val_t          a_x, a_y, b_x, b_y, a_out, b_out;
  val_t          fac_rd, ifac_rd_a, ifac_rd_b;

  logic               accept, pop, push, ok;
  logic signed [11:0] diff;
  logic [AW-1:0]      top_ext, diff_ext, pick_ext;
  logic [D-1:0]       vld_pipe;
  logic [D-1:0]       ok_pipe;
  val_t               fac_dly [L];
  val_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_PW:0]   wr_ptr, rd_ptr, outstanding, fifo_count;

  assign diff     = top_count - pick_count;
  assign top_ext  = AW'($unsigned(top_count));
  assign pick_ext = AW'($unsigned(pick_count));
  assign diff_ext = AW'($unsigned(diff));
  assign ok = !top_count[11] && !pick_count[11] && (pick_count <= top_count)
              && ({1'b0, top_ext} < (AW + 1)'(TABLE_SIZE));

  assign accept     = req_valid && !req_stall;
  assign req_stall  = !tables_ready || (outstanding == DEPTH);
  assign fifo_count = wr_ptr - rd_ptr;
  assign coefficient_valid = (fifo_count != '0);
  assign coefficient = fifo_mem[rd_ptr[FIFO_PW-1:0]];
  assign pop  = coefficient_valid && !coefficient_stall;
  assign push = vld_pipe[D-1];

  mbc_init #(.TABLE_SIZE(TABLE_SIZE), .MODULUS(MODULUS)) u_init (
    .clk(clk), .rst(rst), .a_out(a_out), .b_out(b_out),
    .req(init_req), .wr(wr), .waddr(waddr), .ready(tables_ready)
  );

  mbc_tables #(.TABLE_SIZE(TABLE_SIZE)) u_tables (
    .clk(clk), .wr(wr), .waddr(waddr),
    .fac_addr(top_ext[IW-1:0]),
    .ifac_addr_a(pick_ext[IW-1:0]),
    .ifac_addr_b(diff_ext[IW-1:0]),
    .fac_rd(fac_rd), .ifac_rd_a(ifac_rd_a), .ifac_rd_b(ifac_rd_b)
  );

  assign a_x = tables_ready ? ifac_rd_a : init_req.a_x;
  assign a_y = tables_ready ? ifac_rd_b : init_req.a_y;
  assign b_x = tables_ready ? a_out : init_req.b_x;
  assign b_y = tables_ready ? fac_dly[L-1] : init_req.b_y;

  mbc_modmul #(.MODULUS(MODULUS)) u_mul_a (.clk(clk), .x(a_x), .y(a_y), .z(a_out));
  mbc_modmul #(.MODULUS(MODULUS)) u_mul_b (.clk(clk), .x(b_x), .y(b_y), .z(b_out));

  always_ff @(posedge clk) begin
    ok_pipe    <= {ok_pipe[D-2:0], ok};
    fac_dly[0] <= fac_rd;
    for (int i = 1; i < L; i++) begin
      fac_dly[i] <= fac_dly[i-1];
    end
    if (push) begin
      fifo_mem[wr_ptr[FIFO_PW-1:0]] <= ok_pipe[D-1] ? b_out : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe    <= '0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      outstanding <= '0;
    end else begin
      vld_pipe    <= {vld_pipe[D-2:0], accept};
      wr_ptr      <= wr_ptr + (FIFO_PW + 1)'(push);
      rd_ptr      <= rd_ptr + (FIFO_PW + 1)'(pop);
      outstanding <= outstanding + (FIFO_PW + 1)'(accept) - (FIFO_PW + 1)'(pop);
    end
  end

  `MBC_ASSERT_IMP(a_outstanding_bound, clk, rst, 1'b1, outstanding <= DEPTH)
  `MBC_ASSERT_IMP(a_fifo_within_outstanding, clk, rst, 1'b1, fifo_count <= outstanding)
  `MBC_ASSERT_IMP(a_result_after_ready, clk, rst, coefficient_valid, tables_ready)
  `MBC_ASSERT_NXT(a_ready_holds, clk, rst, tables_ready, tables_ready)

endmodule

// ===== test/modular_binomial_coefficient_test.sv =====
`timescale 1ns / 1ps
module modular_binomial_coefficient_test;

  localparam int SLOTS = 2048;
  localparam longint unsigned PRIME = 64'd1000000007;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [11:0] top;
    logic signed [11:0] pick;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [11:0] top_count = '0;
  logic signed [11:0] pick_count = '0;
  logic coefficient_valid;
  logic coefficient_stall = 1'b0;
  logic [29:0] coefficient;

  longint unsigned fact [SLOTS];
  longint unsigned inv_fact [SLOTS];
  request_t pending_requests [$];
  logic [29:0] expected_coefficients [$];
  int popped = 0;
  int checked = 0;
  int mismatches = 0;
  int cycles = 0;
  bit sent = 1'b0;
  bit drained_once = 1'b0;
  bit stimulus_done = 1'b0;

  modular_binomial_coefficient dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .top_count(top_count), .pick_count(pick_count),
    .coefficient_valid(coefficient_valid), .coefficient_stall(coefficient_stall),
    .coefficient(coefficient)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned fermat_power(longint unsigned base,
                                                   longint unsigned power);
    longint unsigned acc;
    acc = 1;
    base = base % PRIME;
    while (power != 0) begin
      if (power[0]) acc = (acc * base) % PRIME;
      base = (base * base) % PRIME;
      power = power >> 1;
    end
    return acc;
  endfunction

  function automatic logic [29:0] choose_mod(logic signed [11:0] top,
                                             logic signed [11:0] pick);
    longint unsigned partial;
    int n;
    int k;
    n = top;
    k = pick;
    if (n < 0 || k < 0 || k > n || n >= SLOTS) return '0;
    partial = (inv_fact[k] * inv_fact[n - k]) % PRIME;
    return 30'((partial * fact[n]) % PRIME);
  endfunction

  function automatic int sender_idle_pct();
    if (popped < 600) return 38;
    if (popped < 1200) return 58;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (popped < 600) return 58;
    if (popped < 1200) return 38;
    return 0;
  endfunction

  task automatic add_request(int top, int pick);
    request_t r;
    r.top = 12'(top);
    r.pick = 12'(pick);
    pending_requests.push_back(r);
  endtask

  // accept requests and check results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_coefficients.push_back(choose_mod(top_count, pick_count));
        sent = 1'b1;
      end
      if (coefficient_valid && !coefficient_stall) begin
        if (expected_coefficients.size() == 0) begin
          $display("%0t: unexpected coefficient %0d", $time, coefficient);
          mismatches++;
        end else begin
          if (coefficient !== expected_coefficients[0]) begin
            $display("%0t: coefficient expected %0d actual %0d", $time,
                     expected_coefficients[0], coefficient);
            mismatches++;
          end
          void'(expected_coefficients.pop_front());
          checked++;
        end
      end
    end
  end

  // drive requests and result stalls
  always @(negedge clk) begin
    coefficient_stall = ($urandom_range(99) < receiver_idle_pct());
    if (!req_valid || sent) begin
      sent = 1'b0;
      if (popped == 300 && !drained_once) begin
        if (expected_coefficients.size() == 0) drained_once = 1'b1;
        req_valid = 1'b0;
      end else if (pending_requests.size() != 0 && !rst &&
                   $urandom_range(99) >= sender_idle_pct()) begin
        top_count = pending_requests[0].top;
        pick_count = pending_requests[0].pick;
        void'(pending_requests.pop_front());
        popped++;
        req_valid = 1'b1;
      end else begin
        req_valid = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results checked", cycles, checked);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int n;
    fact[0] = 1;
    inv_fact[0] = 1;
    for (int i = 1; i < SLOTS; i++) begin
      fact[i] = (fact[i - 1] * longint'(i)) % PRIME;
      inv_fact[i] = (inv_fact[i - 1] * fermat_power(i, PRIME - 2)) % PRIME;
    end

    add_request(0, 0);
    add_request(2047, 0);
    add_request(2047, 2047);
    add_request(2047, 1023);
    add_request(2047, 2046);
    add_request(2047, 1);
    add_request(1, 1);
    add_request(100, 50);
    add_request(-2048, -2048);
    add_request(-1, 0);
    add_request(0, -1);
    add_request(2047, -1);
    add_request(-1, -2048);
    add_request(5, 6);
    add_request(0, 2047);
    add_request(1024, 2047);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if ($urandom_range(99) < 75) begin
        n = $urandom_range(2047);
        add_request(n, $urandom_range(n));
      end else begin
        add_request($urandom_range(4095), $urandom_range(4095));
      end
    end

    repeat (3) @(negedge clk);
    rst = 1'b0;

    wait (pending_requests.size() == 0 && !req_valid && expected_coefficients.size() == 0);
    repeat (30) @(posedge clk);
    $display("checked %0d coefficients from %0d requests, with paced, stalled",
             checked, popped);
    $display("and free-running phases plus one full drain");
    if (mismatches == 0 && expected_coefficients.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
